@@ hdl/brfc_pkg.sv @@
// Shared types and constants of the memory bridge flow control block.
// Used by the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package brfc_pkg;

	localparam int LIMIT_W   = 5;
	localparam int COUNT_W   = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_LIMIT = 1'd1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [1:0] {
		KIND_REQUEST  = 2'd0,
		KIND_FORWARD  = 2'd1,
		KIND_RESPONSE = 2'd2,
		KIND_REPLY    = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

@@ hdl/brfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module brfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/brfc_ctrl.sv @@
// Controller of the bridge flow control block: takes a word, runs its execute
// step, then strobes the result. Depends on brfc_pkg.
`default_nettype none

module brfc_ctrl import brfc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q == ST_EXEC);
	assign done = done_q;

endmodule

`default_nettype wire

@@ hdl/brfc_datapath.sv @@
// Datapath of the bridge flow control block: limit registers, both queues
// with their pointers and counts, the reservation count and the retry flag.
// Depends on brfc_pkg and brfc_ram.
`default_nettype none

module brfc_datapath import brfc_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctrl_cmd_t            cmd,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [LIMIT_W-1:0]   cfg_wdata,
	input  wire logic [1:0]           kind,
	input  wire logic [TAG_BITS-1:0]  tag,
	input  wire logic                 needs_response,
	input  wire logic                 partner_ready,
	output logic                      accepted,
	output logic                      forward_valid,
	output logic [TAG_BITS-1:0]       forward_tag,
	output logic                      reply_valid,
	output logic [TAG_BITS-1:0]       reply_tag,
	output logic                      retry_signal,
	output logic [COUNT_W-1:0]        request_count,
	output logic [COUNT_W-1:0]        reserved_count
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [LW-1:0] DEPTH_X  = LW'(QUEUE_DEPTH);

	// configuration
	logic [LIMIT_W-1:0] req_limit_q, rsp_limit_q;

	// latched word
	kind_t               kind_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                needs_q;
	logic                ready_q;

	// queue state
	logic [AW-1:0] req_head_q, req_tail_q, rsp_head_q, rsp_tail_q;
	logic [CW-1:0] req_occ_q, rsp_occ_q, rsv_q;
	logic          retry_q;

	logic [TAG_BITS-1:0] req_rdata, rsp_rdata;

	// execute decisions
	logic [LW-1:0] req_lim_eff, rsp_lim_eff, req_lim_x, rsp_lim_x;
	logic          req_full, rsv_full;
	logic          push_req, pop_req, push_rsp, pop_rsp;
	logic          retry_set, retry_clr;
	logic [CW-1:0] req_occ_d, rsv_d;
	logic [LW-1:0] req_occ_x, rsv_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_limit_q <= LIMIT_RESET;
			rsp_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REQUEST_LIMIT:  req_limit_q <= cfg_wdata;
				REG_RESPONSE_LIMIT: rsp_limit_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_t'(kind);
			tag_q   <= tag;
			needs_q <= needs_response;
			ready_q <= partner_ready;
		end
	end

	// a limit above the queue depth acts as the depth
	assign req_lim_x   = LW'(req_limit_q);
	assign rsp_lim_x   = LW'(rsp_limit_q);
	assign req_lim_eff = (req_lim_x > DEPTH_X) ? DEPTH_X : req_lim_x;
	assign rsp_lim_eff = (rsp_lim_x > DEPTH_X) ? DEPTH_X : rsp_lim_x;
	assign req_occ_x   = LW'(req_occ_q);
	assign rsv_x       = LW'(rsv_q);
	assign req_full    = (req_occ_x >= req_lim_eff);
	assign rsv_full    = (rsv_x >= rsp_lim_eff);

	always_comb begin
		push_req  = 1'b0;
		pop_req   = 1'b0;
		push_rsp  = 1'b0;
		pop_rsp   = 1'b0;
		retry_set = 1'b0;
		retry_clr = 1'b0;
		unique case (kind_q)
			KIND_REQUEST: begin
				if (!retry_q) begin
					if (req_full || (needs_q && rsv_full)) begin
						retry_set = 1'b1;
					end else begin
						push_req = 1'b1;
					end
				end
			end
			KIND_FORWARD: begin
				if (ready_q && (req_occ_q != '0)) begin
					pop_req   = 1'b1;
					retry_clr = retry_q;
				end
			end
			KIND_RESPONSE: begin
				// drop a response that finds its queue full
				push_rsp = (rsp_occ_q != FULL_CNT);
			end
			KIND_REPLY: begin
				if (ready_q && (rsp_occ_q != '0)) begin
					pop_rsp   = 1'b1;
					retry_clr = retry_q && !req_full;
				end
			end
		endcase
	end

	always_comb begin
		req_occ_d = req_occ_q;
		if (push_req) begin
			req_occ_d = req_occ_q + 1'b1;
		end else if (pop_req) begin
			req_occ_d = req_occ_q - 1'b1;
		end
		rsv_d = rsv_q;
		if (push_req && needs_q) begin
			rsv_d = rsv_q + 1'b1;
		end else if (pop_rsp && (rsv_q != '0)) begin
			rsv_d = rsv_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_head_q <= '0;
			req_tail_q <= '0;
			rsp_head_q <= '0;
			rsp_tail_q <= '0;
			req_occ_q  <= '0;
			rsp_occ_q  <= '0;
			rsv_q      <= '0;
			retry_q    <= 1'b0;
		end else if (cmd.exec) begin
			req_occ_q <= req_occ_d;
			rsv_q     <= rsv_d;
			if (push_req) begin
				req_tail_q <= (req_tail_q == LAST_PTR) ? '0 : req_tail_q + 1'b1;
			end
			if (pop_req) begin
				req_head_q <= (req_head_q == LAST_PTR) ? '0 : req_head_q + 1'b1;
			end
			if (push_rsp) begin
				rsp_tail_q <= (rsp_tail_q == LAST_PTR) ? '0 : rsp_tail_q + 1'b1;
				rsp_occ_q  <= rsp_occ_q + 1'b1;
			end else if (pop_rsp) begin
				rsp_head_q <= (rsp_head_q == LAST_PTR) ? '0 : rsp_head_q + 1'b1;
				rsp_occ_q  <= rsp_occ_q - 1'b1;
			end
			if (retry_set) begin
				retry_q <= 1'b1;
			end else if (retry_clr) begin
				retry_q <= 1'b0;
			end
		end
	end

	// head entries are read every cycle; the read is ready by the execute cycle
	brfc_ram #(
		.WIDTH (TAG_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_req_ram (
		.clk   (clk),
		.we    (cmd.exec && push_req),
		.waddr (req_tail_q),
		.wdata (tag_q),
		.raddr (req_head_q),
		.rdata (req_rdata)
	);

	brfc_ram #(
		.WIDTH (TAG_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_rsp_ram (
		.clk   (clk),
		.we    (cmd.exec && push_rsp),
		.waddr (rsp_tail_q),
		.wdata (tag_q),
		.raddr (rsp_head_q),
		.rdata (rsp_rdata)
	);

	// result word, held until the next execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted      <= 1'b0;
			forward_valid <= 1'b0;
			forward_tag   <= '0;
			reply_valid   <= 1'b0;
			reply_tag     <= '0;
			retry_signal  <= 1'b0;
			request_count <= '0;
			reserved_count <= '0;
		end else if (cmd.exec) begin
			accepted       <= push_req;
			forward_valid  <= pop_req;
			forward_tag    <= pop_req ? req_rdata : '0;
			reply_valid    <= pop_rsp;
			reply_tag      <= pop_rsp ? rsp_rdata : '0;
			retry_signal   <= retry_clr;
			request_count  <= COUNT_W'(LW'(req_occ_d));
			reserved_count <= COUNT_W'(LW'(rsv_d));
		end
	end

endmodule

`default_nettype wire

@@ hdl/bridge_request_response_flow_control_core.sv @@
// Request/response flow control of a memory bridge.
//
// Drive one event word on kind, tag, needs_response and partner_ready with
// start high; the word is taken at the clock edge where start is high and
// busy is low. busy then stays high for one cycle while the event runs,
// and the cycle after that done is high for exactly one cycle with the
// result on accepted, forward_*, reply_*, retry_signal, request_count and
// reserved_count. The result ports hold until the next result.
// A new word can be taken during the done cycle of the previous one; while
// busy is high start is not taken, so each word is through before the next.
// The receiver cannot stall: each result is taken in its done cycle.
// The user must write limits on cfg_we/cfg_idx/cfg_wdata while the block is
// idle; the block itself does not enforce this.
// Reset (arst_n low) empties both queues, clears the reservation count and
// the retry flag and sets both limits to 16. No clearing pass is needed.
`default_nettype none

module bridge_request_response_flow_control_core import brfc_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	output logic                      done,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [LIMIT_W-1:0]   cfg_wdata,
	input  wire logic [1:0]           kind,
	input  wire logic [TAG_BITS-1:0]  tag,
	input  wire logic                 needs_response,
	input  wire logic                 partner_ready,
	output logic                      accepted,
	output logic                      forward_valid,
	output logic [TAG_BITS-1:0]       forward_tag,
	output logic                      reply_valid,
	output logic [TAG_BITS-1:0]       reply_tag,
	output logic                      retry_signal,
	output logic [COUNT_W-1:0]        request_count,
	output logic [COUNT_W-1:0]        reserved_count
);

	ctrl_cmd_t cmd;

	brfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	brfc_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.kind           (kind),
		.tag            (tag),
		.needs_response (needs_response),
		.partner_ready  (partner_ready),
		.accepted       (accepted),
		.forward_valid  (forward_valid),
		.forward_tag    (forward_tag),
		.reply_valid    (reply_valid),
		.reply_tag      (reply_tag),
		.retry_signal   (retry_signal),
		.request_count  (request_count),
		.reserved_count (reserved_count)
	);

endmodule

`default_nettype wire

@@ hdl/brfc_checker.sv @@
// Port-level checks of the bridge flow control block, bound to the top.
// Depends on bridge_request_response_flow_control_core.
`default_nettype none

module brfc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic accepted,
	input wire logic forward_valid,
	input wire logic reply_valid,
	input wire logic retry_signal
);

	// the execute state of an event ends and is followed by its result strobe
	a_exec_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("execute cycle not followed by result strobe");

	a_single_send: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(forward_valid && reply_valid))
		else $error("both queues sent in one event");

	a_accept_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (!forward_valid && !reply_valid && !retry_signal))
		else $error("queued request reported together with a send");

	a_retry_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		(done && retry_signal) |-> (forward_valid || reply_valid))
		else $error("retry released without a send");

endmodule

bind bridge_request_response_flow_control_core brfc_checker u_brfc_checker (.*);

`default_nettype wire

@@ sim/tb_bridge_request_response_flow_control_core.sv @@
// Testbench for the memory bridge flow control core. A driver and a monitor
// check each result word against a scoreboard model of the queues and counters.
// Depends on brfc_pkg and bridge_request_response_flow_control_core.

module tb_bridge_request_response_flow_control_core;
	import brfc_pkg::*;

	localparam int DEPTH       = 16;
	localparam int TAG_W       = 8;
	localparam int NPHASE      = 8;
	localparam int PHASE_WORDS = 175;
	localparam int MAX_REPORTS = 40;
	localparam int MAX_WORDS   = 2048;

	typedef struct packed {
		kind_t            kind;
		logic [TAG_W-1:0] tag;
		logic             needs;
		logic             ready;
	} bridge_word_t;

	typedef struct packed {
		logic               accepted;
		logic               fwd_valid;
		logic [TAG_W-1:0]   fwd_tag;
		logic               rep_valid;
		logic [TAG_W-1:0]   rep_tag;
		logic               retry;
		logic [COUNT_W-1:0] req_count;
		logic [COUNT_W-1:0] res_count;
	} bridge_result_t;

	logic                 clk;
	logic                 arst_n         = 1'b0;
	logic                 start          = 1'b0;
	logic                 cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx        = REG_REQUEST_LIMIT;
	logic [LIMIT_W-1:0]   cfg_wdata      = '0;
	logic [1:0]           kind           = KIND_REQUEST;
	logic [TAG_W-1:0]     tag            = '0;
	logic                 needs_response = 1'b0;
	logic                 partner_ready  = 1'b0;
	logic                 busy, done, accepted, forward_valid, reply_valid, retry_signal;
	logic [TAG_W-1:0]     forward_tag, reply_tag;
	logic [COUNT_W-1:0]   request_count, reserved_count;

	bridge_request_response_flow_control_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.kind(kind), .tag(tag), .needs_response(needs_response),
		.partner_ready(partner_ready), .accepted(accepted),
		.forward_valid(forward_valid), .forward_tag(forward_tag),
		.reply_valid(reply_valid), .reply_tag(reply_tag),
		.retry_signal(retry_signal), .request_count(request_count),
		.reserved_count(reserved_count)
	);

	// scoreboard copy of the bridge
	logic [TAG_W-1:0] req_q [DEPTH];
	logic [TAG_W-1:0] rsp_q [DEPTH];
	int req_head = 0, req_occ = 0, rsp_head = 0, rsp_occ = 0, reserved = 0;
	bit stalled = 1'b0;
	int req_limit = 16, rsp_limit = 16;

	bridge_word_t   pending_words [MAX_WORDS];
	int             pend_wr = 0, pend_rd = 0;
	bridge_result_t expected_results [MAX_WORDS];
	int             exp_wr = 0, exp_rd = 0;
	bit taken = 1'b0;
	bit idle_gaps = 1'b1;
	int gap_left = 0;
	int errors = 0;
	int n_results = 0, n_queued = 0, n_forwarded = 0, n_replies = 0, n_retries = 0;
	int n_dropped = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_limit(int lim);
		return lim > DEPTH ? DEPTH : lim;
	endfunction

	function automatic bridge_result_t bridge_step(bridge_word_t w);
		bridge_result_t r;
		r = '0;
		case (w.kind)
			KIND_REQUEST: begin
				if (!stalled) begin
					if (req_occ >= eff_limit(req_limit)) begin
						stalled = 1'b1;
					end else if (w.needs && reserved >= eff_limit(rsp_limit)) begin
						stalled = 1'b1;
					end else begin
						if (w.needs)
							reserved++;
						req_q[(req_head + req_occ) % DEPTH] = w.tag;
						req_occ++;
						r.accepted = 1'b1;
					end
				end
			end
			KIND_FORWARD: begin
				if (w.ready && req_occ > 0) begin
					r.fwd_valid = 1'b1;
					r.fwd_tag   = req_q[req_head];
					req_head    = (req_head + 1) % DEPTH;
					req_occ--;
					if (stalled) begin
						stalled = 1'b0;
						r.retry = 1'b1;
					end
				end
			end
			KIND_RESPONSE: begin
				if (rsp_occ < DEPTH) begin
					rsp_q[(rsp_head + rsp_occ) % DEPTH] = w.tag;
					rsp_occ++;
				end else begin
					n_dropped++;
				end
			end
			default: begin
				if (w.ready && rsp_occ > 0) begin
					r.rep_valid = 1'b1;
					r.rep_tag   = rsp_q[rsp_head];
					rsp_head    = (rsp_head + 1) % DEPTH;
					rsp_occ--;
					if (reserved > 0)
						reserved--;
					if (stalled && req_occ < eff_limit(req_limit)) begin
						stalled = 1'b0;
						r.retry = 1'b1;
					end
				end
			end
		endcase
		r.req_count = COUNT_W'(req_occ);
		r.res_count = COUNT_W'(reserved);
		return r;
	endfunction

	function automatic bridge_word_t make_word(kind_t k, int t, bit n, bit r);
		bridge_word_t w;
		w.kind  = k;
		w.tag   = TAG_W'(t);
		w.needs = n;
		w.ready = r;
		return w;
	endfunction

	function automatic bridge_word_t random_word(int w_req, int w_fwd, int w_rsp, int w_rep);
		int pick;
		kind_t k;
		pick = $urandom_range(0, w_req + w_fwd + w_rsp + w_rep - 1);
		if (pick < w_req)
			k = KIND_REQUEST;
		else if (pick < w_req + w_fwd)
			k = KIND_FORWARD;
		else if (pick < w_req + w_fwd + w_rsp)
			k = KIND_RESPONSE;
		else
			k = KIND_REPLY;
		return make_word(k, $urandom_range(0, 255), $urandom_range(0, 1),
			$urandom_range(0, 3) != 0);
	endfunction

	// mostly back to back, sometimes a short pause, rarely a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// append a word to the driver's list
	task automatic add_word(bridge_word_t w);
		pending_words[pend_wr] = w;
		pend_wr++;
	endtask

	// driver: present the next word once the current one has been taken
	always @(negedge clk) begin
		bridge_word_t w;
		if (arst_n && (!start || taken)) begin
			taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pend_rd < pend_wr) begin
				w = pending_words[pend_rd];
				pend_rd++;
				kind           <= w.kind;
				tag            <= w.tag;
				needs_response <= w.needs;
				partner_ready  <= w.ready;
				start          <= 1'b1;
				gap_left = idle_gaps ? pick_gap() : 0;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic report(string field, int exp_val, int act_val);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, act_val);
	endtask

	// monitor: predict on each taken word, check each done strobe
	always @(posedge clk) begin
		bridge_result_t exp_r, got;
		if (arst_n) begin
			if (start && !busy) begin
				expected_results[exp_wr] = bridge_step(make_word(kind_t'(kind), tag,
					needs_response, partner_ready));
				exp_wr++;
				taken = 1'b1;
			end
			if (done) begin
				if (exp_rd == exp_wr) begin
					report("unexpected result word", 0, 1);
				end else begin
					exp_r = expected_results[exp_rd];
					exp_rd++;
					got   = {accepted, forward_valid, forward_tag, reply_valid, reply_tag,
						retry_signal, request_count, reserved_count};
					n_results++;
					n_queued    += exp_r.accepted;
					n_forwarded += exp_r.fwd_valid;
					n_replies   += exp_r.rep_valid;
					n_retries   += exp_r.retry;
					if (got.accepted !== exp_r.accepted)
						report("accepted", exp_r.accepted, got.accepted);
					if (got.fwd_valid !== exp_r.fwd_valid)
						report("forward_valid", exp_r.fwd_valid, got.fwd_valid);
					if (got.fwd_tag !== exp_r.fwd_tag)
						report("forward_tag", exp_r.fwd_tag, got.fwd_tag);
					if (got.rep_valid !== exp_r.rep_valid)
						report("reply_valid", exp_r.rep_valid, got.rep_valid);
					if (got.rep_tag !== exp_r.rep_tag)
						report("reply_tag", exp_r.rep_tag, got.rep_tag);
					if (got.retry !== exp_r.retry)
						report("retry_signal", exp_r.retry, got.retry);
					if (got.req_count !== exp_r.req_count)
						report("request_count", exp_r.req_count, got.req_count);
					if (got.res_count !== exp_r.res_count)
						report("reserved_count", exp_r.res_count, got.res_count);
				end
			end
		end
	end

	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= LIMIT_W'(value);
		if (idx == REG_REQUEST_LIMIT)
			req_limit = value;
		else
			rsp_limit = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until the driver is drained and every result word is back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pend_rd != pend_wr || start || exp_rd != exp_wr);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		int req_tab [NPHASE] = '{1, 0, 31, 16, 3, 16, 5, 16};
		int rsp_tab [NPHASE] = '{1, 5, 31, 0, 16, 16, 2, 16};
		int mix_tab [NPHASE][4] = '{'{3, 3, 3, 3}, '{4, 2, 2, 2}, '{3, 2, 3, 2},
			'{4, 2, 1, 1}, '{4, 1, 2, 3}, '{5, 3, 1, 0}, '{1, 1, 6, 1}, '{3, 3, 3, 3}};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset limits: empty heads, not-ready partners, tag extremes
		add_word(make_word(KIND_FORWARD, 8'h00, 0, 1));
		add_word(make_word(KIND_REPLY, 8'h00, 0, 1));
		add_word(make_word(KIND_REQUEST, 8'h00, 1, 0));
		add_word(make_word(KIND_REQUEST, 8'hff, 0, 1));
		add_word(make_word(KIND_FORWARD, 8'h11, 1, 0));
		add_word(make_word(KIND_FORWARD, 8'h22, 0, 1));
		add_word(make_word(KIND_RESPONSE, 8'hff, 1, 1));
		add_word(make_word(KIND_RESPONSE, 8'h00, 0, 0));
		add_word(make_word(KIND_REPLY, 8'h33, 1, 0));
		add_word(make_word(KIND_REPLY, 8'h44, 0, 1));
		// second reply finds no reservation left
		add_word(make_word(KIND_REPLY, 8'h55, 1, 1));
		add_word(make_word(KIND_FORWARD, 8'h66, 1, 1));
		wait_idle();

		// tight limits: slot exhaustion, stalled requests, full queue, retries
		write_limit(REG_REQUEST_LIMIT, 2);
		write_limit(REG_RESPONSE_LIMIT, 1);
		add_word(make_word(KIND_REQUEST, 8'h5a, 1, 0));
		add_word(make_word(KIND_REQUEST, 8'h77, 1, 0));
		add_word(make_word(KIND_REQUEST, 8'h88, 0, 0));
		add_word(make_word(KIND_FORWARD, 8'h00, 0, 1));
		add_word(make_word(KIND_REQUEST, 8'ha5, 0, 1));
		add_word(make_word(KIND_REQUEST, 8'h3c, 0, 1));
		add_word(make_word(KIND_REQUEST, 8'h99, 1, 1));
		add_word(make_word(KIND_RESPONSE, 8'hc3, 0, 0));
		add_word(make_word(KIND_REPLY, 8'h00, 0, 1));
		add_word(make_word(KIND_FORWARD, 8'h00, 1, 1));
		add_word(make_word(KIND_FORWARD, 8'h00, 0, 1));
		wait_idle();

		for (int p = 0; p < NPHASE; p++) begin
			if (p == NPHASE - 1) begin
				req_tab[p] = $urandom_range(0, 31);
				rsp_tab[p] = $urandom_range(0, 31);
			end
			write_limit(REG_REQUEST_LIMIT, req_tab[p]);
			write_limit(REG_RESPONSE_LIMIT, rsp_tab[p]);
			idle_gaps = (p % 3) != 1;
			for (int n = 0; n < PHASE_WORDS; n++)
				add_word(random_word(mix_tab[p][0], mix_tab[p][1],
					mix_tab[p][2], mix_tab[p][3]));
			wait_idle();
		end

		repeat (5) @(posedge clk);
		$display("Checked %0d result words: %0d requests queued, %0d forwarded, %0d replies,",
			n_results, n_queued, n_forwarded, n_replies);
		$display("%0d retries, %0d responses dropped, over %0d limit settings",
			n_retries, n_dropped, NPHASE + 2);
		if (errors == 0)
			$display("PASS bridge_request_response_flow_control_core");
		else
			$display("FAIL bridge_request_response_flow_control_core");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL bridge_request_response_flow_control_core");
		$finish;
	end

endmodule
